/* hdl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants and helpers for the polynomial sine / cosine unit: angle
// constants and Horner coefficients held at 32 fractional bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  // angle constants, Q.32
  localparam longint Q32_HALF_PI       = 64'sd6746518852;
  localparam longint Q32_PI            = 64'sd13493037705;
  localparam longint Q32_THREE_HALF_PI = 64'sd20239556557;
  localparam longint Q32_TWO_PI        = 64'sd26986075409;

  // horner coefficients a..e, Q.32
  localparam int NUM_COEF = 5;
  localparam longint COEF_Q32 [NUM_COEF] = '{
    64'sd25166288,
    64'sd24000015,
    -64'sd736890657,
    64'sd7810606,
    64'sd4294011062
  };

  // reduce a Q.32 constant to frac bits, nearest, ties away from zero
  function automatic longint from_q32(input longint v, input int frac);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r   = (mag + (64'sd1 <<< (31 - frac))) >>> (32 - frac);
    return (v < 0) ? -r : r;
  endfunction

endpackage

`default_nettype wire

/* hdl/psc_range.sv */
// ----------------------------------------------------------------------------
// psc_range
// Angle reduction cells: cosine offset, wrap into [0, 2pi), quadrant fold
// into a quarter-wave argument. Three registered steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_range #(
  parameter int FRAC_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  wire  signed [FRAC_BITS+3:0] angle_i,
  input  wire                        command_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output logic signed [FRAC_BITS+2:0] x_o
);

  localparam int WW = FRAC_BITS + 6;
  localparam int TW = FRAC_BITS + 3;

  localparam longint HP_L  = psc_pkg::from_q32(psc_pkg::Q32_HALF_PI, FRAC_BITS);
  localparam longint PI_L  = psc_pkg::from_q32(psc_pkg::Q32_PI, FRAC_BITS);
  localparam longint THP_L = psc_pkg::from_q32(psc_pkg::Q32_THREE_HALF_PI, FRAC_BITS);
  localparam longint TP_L  = psc_pkg::from_q32(psc_pkg::Q32_TWO_PI, FRAC_BITS);

  localparam logic signed [WW-1:0] HALF_PI       = HP_L[WW-1:0];
  localparam logic signed [WW-1:0] PI            = PI_L[WW-1:0];
  localparam logic signed [WW-1:0] THREE_HALF_PI = THP_L[WW-1:0];
  localparam logic signed [WW-1:0] TWO_PI        = TP_L[WW-1:0];
  localparam logic signed [WW-1:0] NEG_TWO_PI    = -TP_L[WW-1:0];

  logic                 va_q, vb_q, vc_q;
  logic                 rdy_a, rdy_b, rdy_c;
  logic signed [WW-1:0] xa_q, xa_d;
  logic signed [WW-1:0] xb_q, xb_d;
  logic signed [TW-1:0] xc_q;
  logic signed [WW-1:0] fold_s;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vc_q;
  assign x_o     = xc_q;

  // cosine offset
  always_comb begin
    xa_d = WW'(angle_i);
    if (command_i) begin
      xa_d = WW'(angle_i) + HALF_PI;
    end
  end

  // wrap, at most two turns of 2pi below zero
  always_comb begin
    if (xa_q >= TWO_PI) begin
      xb_d = xa_q - TWO_PI;
    end else if (xa_q >= 0) begin
      xb_d = xa_q;
    end else if (xa_q >= NEG_TWO_PI) begin
      xb_d = xa_q + TWO_PI;
    end else begin
      xb_d = xa_q + TWO_PI + TWO_PI;
    end
  end

  // quadrant fold
  always_comb begin
    if (xb_q < HALF_PI) begin
      fold_s = xb_q;
    end else if (xb_q < THREE_HALF_PI) begin
      fold_s = PI - xb_q;
    end else begin
      fold_s = xb_q - TWO_PI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) xa_q <= xa_d;
    if (rdy_b && va_q)    xb_q <= xb_d;
    if (rdy_c && vb_q)    xc_q <= fold_s[TW-1:0];
  end

endmodule

`default_nettype wire

/* hdl/psc_horner_cell.sv */
// ----------------------------------------------------------------------------
// psc_horner_cell
// One Horner step: t' = round(t * x) + coefficient, argument passed along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_horner_cell #(
  parameter int     FRAC_BITS = 16,
  parameter longint COEF_Q32  = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  wire  signed [FRAC_BITS+2:0] t_i,
  input  wire  signed [FRAC_BITS+2:0] x_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output logic signed [FRAC_BITS+2:0] t_o,
  output logic signed [FRAC_BITS+2:0] x_o
);

  localparam int     TW     = FRAC_BITS + 3;
  localparam int     PW     = 2 * TW;
  localparam longint COEF_L = psc_pkg::from_q32(COEF_Q32, FRAC_BITS);
  localparam logic signed [TW-1:0] COEF = COEF_L[TW-1:0];
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic                 valid_q;
  logic signed [TW-1:0] t_q, t_d;
  logic signed [TW-1:0] x_q;
  logic signed [PW-1:0] prod_s, rnd_s, shr_s;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign t_o     = t_q;
  assign x_o     = x_q;

  // round to nearest, ties away from zero
  always_comb begin
    prod_s = t_i * x_i;
    rnd_s  = prod_s[PW-1] ? (prod_s + HALF - PW'(1)) : (prod_s + HALF);
    shr_s  = rnd_s >>> FRAC_BITS;
    t_d    = shr_s[TW-1:0] + COEF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      t_q <= t_d;
      x_q <= x_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/psc_sat_cell.sv */
// ----------------------------------------------------------------------------
// psc_sat_cell
// Output cell: clamp to plus or minus one and hold the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_sat_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  wire  signed [FRAC_BITS+2:0] t_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output logic signed [FRAC_BITS+1:0] value_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam int VW = FRAC_BITS + 2;
  localparam logic signed [TW-1:0] ONE_T     = TW'(1) <<< FRAC_BITS;
  localparam logic signed [TW-1:0] NEG_ONE_T = -(TW'(1) <<< FRAC_BITS);

  logic                 valid_q;
  logic signed [VW-1:0] value_q, value_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign value_o = value_q;

  always_comb begin
    if (t_i > ONE_T) begin
      value_d = ONE_T[VW-1:0];
    end else if (t_i < NEG_ONE_T) begin
      value_d = NEG_ONE_T[VW-1:0];
    end else begin
      value_d = t_i[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q <= value_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/poly_sine_cosine_unit.sv */
// ----------------------------------------------------------------------------
// poly_sine_cosine_unit
// Pipeline: 3 reduction registers, 5 Horner cells, 1 output register.
// Throughput: one angle per cycle while out_stall_i is low; each cell
// holds one item and hands it on, and each Horner cell has one multiplier.
// Reset clears only the valid flags of the cells; payload registers keep data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module poly_sine_cosine_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // input channel
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  signed [FRAC_BITS+3:0] angle_i,
  input  wire                         command_i,
  // output channel
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic signed [FRAC_BITS+1:0] value_o
);

  localparam int     TW     = FRAC_BITS + 3;
  localparam int     NCELL  = psc_pkg::NUM_COEF;
  // leading coefficient enters the chain as a constant
  localparam longint A_L    = psc_pkg::from_q32(psc_pkg::COEF_Q32[0], FRAC_BITS);
  localparam logic signed [TW-1:0] A_T = A_L[TW-1:0];

  logic                 range_ready;
  // per-link handshake and payload along the cell chain
  logic                 vld_s [NCELL+1];
  logic                 rdy_s [NCELL+1];
  logic signed [TW-1:0] t_s   [NCELL+1];
  logic signed [TW-1:0] x_s   [NCELL+1];
  logic                 sat_ready;

  assign in_stall_o = !range_ready;
  assign t_s[0]     = A_T;

  // offset, wrap and fold into a quarter-wave argument
  psc_range #(
    .FRAC_BITS (FRAC_BITS)
  ) u_range (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (range_ready),
    .angle_i   (angle_i),
    .command_i (command_i),
    .valid_o   (vld_s[0]),
    .ready_i   (rdy_s[0]),
    .x_o       (x_s[0])
  );

  // horner chain: cells 0..3 add b..e, the last cell only multiplies
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    localparam int     CI = (g < NCELL - 1) ? g + 1 : 0;
    localparam longint CQ = (g < NCELL - 1) ? psc_pkg::COEF_Q32[CI] : 64'sd0;

    psc_horner_cell #(
      .FRAC_BITS (FRAC_BITS),
      .COEF_Q32  (CQ)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[g]),
      .ready_o (rdy_s[g]),
      .t_i     (t_s[g]),
      .x_i     (x_s[g]),
      .valid_o (vld_s[g + 1]),
      .ready_i (rdy_s[g + 1]),
      .t_o     (t_s[g + 1]),
      .x_o     (x_s[g + 1])
    );
  end

  assign rdy_s[NCELL] = sat_ready;

  // clamp and output register
  psc_sat_cell #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_s[NCELL]),
    .ready_o (sat_ready),
    .t_i     (t_s[NCELL]),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .value_o (value_o)
  );

  // argument copy leaving the last cell is not needed past the chain
  logic unused_x;
  assign unused_x = ^x_s[NCELL];

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for poly_sine_cosine_unit. A short table of directed
// angles (zero, quadrant edges, wrap points, field extremes, both commands) is
// followed by random angles. Each accepted untyped input transfer is run
// through a local fixed-point model of the quintic sine / cosine evaluation,
// and each output transfer is compared against the oldest prediction. The
// sender works in random bursts, the receiver stalls on its own pattern and
// once holds off long enough to back the pipe up into the input channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC         = 16;
  localparam int ANGLE_W      = FRAC + 4;
  localparam int VALUE_W      = FRAC + 2;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int HOLD_AT_ITEM = 150;    // random item at which the hold-off starts
  localparam int DRAIN_CYCLES = 30;     // margin for late or extra transfers after draining
  localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer on either side

  // command codes
  localparam bit CMD_SINE   = 1'b0;
  localparam bit CMD_COSINE = 1'b1;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct {
    angle_t angle;
    bit     cmd;
    bit     typed;   // expected value written in the table
    value_t value;
  } stim_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // dut ports, all inputs known from time zero
  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  angle_t                     angle_i     = '0;
  logic                       command_i   = 1'b0;
  logic                       out_stall_i = 1'b0;
  wire                        in_stall_o;
  wire                        out_valid_o;
  wire signed [VALUE_W-1:0]   value_o;

  // predicted results waiting for their output transfer
  value_t      expected_values[$];
  value_t      oldest_value;

  int          errors        = 0;
  int          n_sine        = 0;
  int          n_cosine      = 0;
  int          n_checked     = 0;
  int          n_full_scale  = 0;
  int          burst_left    = 0;

  // receiver pattern state
  stall_mode_e stall_mode    = STALL_NONE;
  int          mode_left     = 0;
  int          hold_left     = 0;
  bit          hold_req      = 1'b0;
  bit          hold_done     = 1'b0;
  int          idle_cycles   = 0;

  poly_sine_cosine_unit #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .angle_i    (angle_i),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // fixed-point model
  // --------------------------------------------------------------------------

  // shift right by sh with rounding to nearest, ties away from zero
  function automatic longint round_away(longint v, int sh);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r   = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -r : r;
  endfunction

  // Q.32 constant brought down to the working fraction
  function automatic longint q32_const(longint v);
    return round_away(v, 32 - FRAC);
  endfunction

  // expected result for one angle / command pair
  function automatic value_t poly_sincos(angle_t angle, bit cmd);
    longint half_pi;
    longint pi_q;
    longint three_half_pi;
    longint two_pi;
    longint one;
    longint x;
    longint acc;
    longint y;
    half_pi       = q32_const(psc_pkg::Q32_HALF_PI);
    pi_q          = q32_const(psc_pkg::Q32_PI);
    three_half_pi = q32_const(psc_pkg::Q32_THREE_HALF_PI);
    two_pi        = q32_const(psc_pkg::Q32_TWO_PI);
    one           = 64'sd1 <<< FRAC;
    x             = longint'(angle);
    // cosine is sine shifted by a quarter turn
    if (cmd == CMD_COSINE) x = x + half_pi;
    // wrap into [0, 2pi)
    while (x >= two_pi) x = x - two_pi;
    while (x < 0) x = x + two_pi;
    // fold onto the quarter wave around zero
    if (x < half_pi) begin
      x = x;
    end else if (x < three_half_pi) begin
      x = pi_q - x;
    end else begin
      x = x - two_pi;
    end
    // horner chain, each product rounded back to the working fraction
    acc = q32_const(psc_pkg::COEF_Q32[0]);
    for (int k = 1; k < psc_pkg::NUM_COEF; k++) begin
      acc = round_away(acc * x, FRAC) + q32_const(psc_pkg::COEF_Q32[k]);
    end
    y = round_away(acc * x, FRAC);
    // clamp to plus or minus one
    if (y > one) y = one;
    if (y < -one) y = -one;
    return value_t'(y);
  endfunction

  function automatic stim_row_t make_row(angle_t a, bit c, bit typed, value_t v);
    stim_row_t r;
    r.angle = a;
    r.cmd   = c;
    r.typed = typed;
    r.value = v;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // sender: one input transfer, then the burst / gap pacing
  // --------------------------------------------------------------------------
  task automatic send_angle(angle_t a, bit c, bit typed, value_t tv);
    value_t predicted;
    int     gap;
    predicted = typed ? tv : poly_sincos(a, c);
    in_valid_i <= 1'b1;
    angle_i    <= a;
    command_i  <= c;
    @(posedge clk_i);
    // payload holds while the input is stalled
    while (in_stall_o) @(posedge clk_i);
    expected_values.push_back(predicted);
    if (c == CMD_COSINE) n_cosine++;
    else n_sine++;
    if (predicted == value_t'(1 <<< FRAC) || predicted == value_t'(-(1 <<< FRAC))) begin
      n_full_scale++;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
      if (gap > 0) begin
        // idle: drop valid and put noise on the payload
        in_valid_i <= 1'b0;
        angle_i    <= angle_t'($urandom);
        command_i  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows[$];
    longint    hp;
    longint    pk;
    longint    thp;
    longint    tp;
    longint    bases[11];
    longint    a;
    value_t    zero;

    hp   = q32_const(psc_pkg::Q32_HALF_PI);
    pk   = q32_const(psc_pkg::Q32_PI);
    thp  = q32_const(psc_pkg::Q32_THREE_HALF_PI);
    tp   = q32_const(psc_pkg::Q32_TWO_PI);
    zero = '0;

    // directed table; the typed rows land exactly on a zero of the fold
    rows.push_back(make_row(angle_t'(0), CMD_SINE, 1'b1, zero));
    rows.push_back(make_row(angle_t'(pk), CMD_SINE, 1'b1, zero));
    rows.push_back(make_row(angle_t'(-hp), CMD_COSINE, 1'b1, zero));
    rows.push_back(make_row(angle_t'(tp), CMD_SINE, 1'b1, zero));
    rows.push_back(make_row(angle_t'(-tp), CMD_SINE, 1'b1, zero));
    rows.push_back(make_row(angle_t'(0), CMD_COSINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(hp - 1), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(hp), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(thp - 1), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(thp), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(tp - 1), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(-hp), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(-pk), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(pk), CMD_COSINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(thp), CMD_COSINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(1), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(-1), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(-1), CMD_COSINE, 1'b0, zero));
    // field extremes, both commands; the bottom angle wraps twice
    rows.push_back(make_row(angle_t'(524287), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(-524288), CMD_SINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(524287), CMD_COSINE, 1'b0, zero));
    rows.push_back(make_row(angle_t'(-524288), CMD_COSINE, 1'b0, zero));

    // points around which the folding and wrapping change
    bases = '{0, hp, pk, thp, tp, -hp, -pk, -thp, -tp, 524287 - hp, -524288};

    // reset, released on a clock edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) begin
      send_angle(rows[i].angle, rows[i].cmd, rows[i].typed, rows[i].value);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // once, back the output up so the input channel stalls
      if (i == HOLD_AT_ITEM) hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: a = bases[$urandom_range(0, 10)] + $urandom_range(0, 8) - 4;
        2: a = longint'($urandom_range(0, 511)) - 256;
        default: a = longint'($urandom);
      endcase
      send_angle(angle_t'(a), 1'($urandom_range(0, 1)), 1'b0, zero);
    end
    in_valid_i <= 1'b0;

    // drain, then give late or extra transfers time to show up
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_values.size() != 0) begin
      $error("value: %0d expected results never arrived", expected_values.size());
      errors++;
    end

    $display("covered %0d sine and %0d cosine transfers, %0d results checked",
             n_sine, n_cosine, n_checked);
    $display("%0d results at full scale, one receiver hold-off of %0d cycles",
             n_full_scale, HOLD_CYCLES);
    if (errors == 0) begin
      $display("poly_sine_cosine_unit: match");
    end else begin
      $display("poly_sine_cosine_unit: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: check each output transfer, then pick the next stall value
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_values.size() == 0) begin
        $error("value: expected none, actual %0d", value_o);
        errors++;
      end else begin
        oldest_value = expected_values.pop_front();
        n_checked++;
        if (value_o !== oldest_value) begin
          $error("value: expected %0d, actual %0d", oldest_value, value_o);
          errors++;
        end
      end
    end

    // stall pattern changes character every so often
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 150);
    end else begin
      mode_left  <= mode_left - 1;
    end

    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_done   <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= mode_left[2];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transfer ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("poly_sine_cosine_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* files.f */
hdl/psc_pkg.sv
hdl/psc_range.sv
hdl/psc_horner_cell.sv
hdl/psc_sat_cell.sv
hdl/poly_sine_cosine_unit.sv
tb/sv/tb_top.sv
